[design/zoh_pkg.sv]
// Shared types and constants for the zero-order hold upsampler and its ring FIFO.
package zoh_pkg;

  localparam int SAMPLE_W = 32;
  localparam int PHASE_W  = 26;
  localparam int FRAC_W   = 16;
  localparam int IDX_W    = 10;
  localparam int COPY_W   = 2;

  // Phase increments per output word, 0.16 format.
  localparam logic [FRAC_W-1:0] INC_LOW  = 16'd30106;
  localparam logic [FRAC_W-1:0] INC_HIGH = 16'd60211;

  localparam logic [COPY_W-1:0] MAX_COPIES = 2'd3;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_PULL = 1'b1;

  localparam logic RATE_LOW  = 1'b0;
  localparam logic RATE_HIGH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_READ
  } zoh_state_t;

endpackage

[design/zoh_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module zoh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/zoh_upsampler_ring_fifo_core.sv]
// Top level: zero-order hold upsampler writing copies of source words into a ring FIFO.
//
//   channel | direction | payload                                   | handshake
//   in_     | in        | req_type, sample_word, first_of_frame     | in_valid / in_ready
//   out_    | out       | out_word, ring_empty                      | out_valid / out_ready
//   cfg_    | in        | rate_select                               | cfg_valid / cfg_ready
//
// A push keeps the block busy while its copies are written, one copy a cycle through the
// ring's single write port; a push into a full frame is dropped without leaving idle. A
// pull reads the ring into the output register, waiting in the read state while that
// register is still held by a stalled consumer.
// Synchronous active-low reset clears the pointers, phase and counts and selects the high
// rate; the ring contents are undefined after reset. Each pull gives one result, a push none.
module zoh_upsampler_ring_fifo_core #(
  parameter int RING_DEPTH  = 16384,
  parameter int FRAME_WORDS = 800
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_req_type,
  input  logic [zoh_pkg::SAMPLE_W-1:0] in_sample_word,
  input  logic                         in_first_of_frame,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [zoh_pkg::SAMPLE_W-1:0] out_word,
  output logic                         out_ring_empty,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_rate_select
);

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);
  localparam logic [zoh_pkg::IDX_W-1:0] FRAME_LEN = zoh_pkg::IDX_W'(FRAME_WORDS);

  zoh_pkg::zoh_state_t state_r, state_nxt;

  logic [PTR_W-1:0]                wp_r, wp_nxt;
  logic [PTR_W-1:0]                rp_r, rp_nxt;
  logic [zoh_pkg::PHASE_W-1:0]     phase_r, phase_nxt;
  logic [zoh_pkg::IDX_W-1:0]       si_r, si_nxt;
  logic [zoh_pkg::IDX_W-1:0]       fc_r, fc_nxt;
  logic [zoh_pkg::COPY_W-1:0]      copies_r, copies_nxt;
  logic                            rate_r;
  logic                            out_valid_r, out_valid_nxt;
  logic [zoh_pkg::SAMPLE_W-1:0]    out_word_r, out_word_nxt;
  logic                            out_empty_r, out_empty_nxt;
  logic [zoh_pkg::SAMPLE_W-1:0]    word_r, word_nxt;
  logic                            empty_r, empty_nxt;

  logic                            in_accept;
  logic                            ring_empty_now;
  logic                            copy_ok;
  logic [zoh_pkg::FRAC_W-1:0]      inc;
  logic [zoh_pkg::IDX_W-1:0]       fc_start;

  logic                            ram_we;
  logic                            ram_re;
  logic [zoh_pkg::SAMPLE_W-1:0]    ram_rdata;

  zoh_ram #(
    .WIDTH (zoh_pkg::SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (word_r),
    .re    (ram_re),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  assign in_ready       = (state_r == zoh_pkg::ST_IDLE);
  assign in_accept      = in_valid && in_ready;
  assign cfg_ready      = 1'b1;
  assign out_valid      = out_valid_r;
  assign out_word       = out_word_r;
  assign out_ring_empty = out_empty_r;

  assign ring_empty_now = (wp_r == rp_r);
  assign inc = (rate_r == zoh_pkg::RATE_HIGH) ? zoh_pkg::INC_HIGH : zoh_pkg::INC_LOW;
  assign fc_start = in_first_of_frame ? '0 : fc_r;

  // A copy is due while the integer part of the phase still points at this source word.
  assign copy_ok = (copies_r != zoh_pkg::MAX_COPIES) && (fc_r < FRAME_LEN) &&
                   (phase_r[zoh_pkg::PHASE_W-1 -: zoh_pkg::IDX_W] == si_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= zoh_pkg::ST_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      phase_r     <= '0;
      si_r        <= '0;
      fc_r        <= '0;
      copies_r    <= '0;
      rate_r      <= zoh_pkg::RATE_HIGH;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      phase_r     <= phase_nxt;
      si_r        <= si_nxt;
      fc_r        <= fc_nxt;
      copies_r    <= copies_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        rate_r <= cfg_rate_select;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    out_empty_r <= out_empty_nxt;
    word_r      <= word_nxt;
    empty_r     <= empty_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    phase_nxt     = phase_r;
    si_nxt        = si_r;
    fc_nxt        = fc_r;
    copies_nxt    = copies_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    out_empty_nxt = out_empty_r;
    word_nxt      = word_r;
    empty_nxt     = empty_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      zoh_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_req_type == zoh_pkg::REQ_PULL) begin
            empty_nxt = ring_empty_now;
            ram_re    = !ring_empty_now;
            state_nxt = zoh_pkg::ST_READ;
          end else begin
            word_nxt   = in_sample_word;
            copies_nxt = '0;
            if (in_first_of_frame) begin
              phase_nxt = '0;
              si_nxt    = '0;
              fc_nxt    = '0;
            end
            // A full frame ignores the item entirely, source index included.
            if (fc_start < FRAME_LEN) begin
              state_nxt = zoh_pkg::ST_PUSH;
            end
          end
        end
      end
      zoh_pkg::ST_PUSH: begin
        if (copy_ok) begin
          ram_we     = 1'b1;
          wp_nxt     = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
          phase_nxt  = phase_r + zoh_pkg::PHASE_W'(inc);
          fc_nxt     = fc_r + 1'b1;
          copies_nxt = copies_r + 1'b1;
        end else begin
          si_nxt    = si_r + 1'b1;
          state_nxt = zoh_pkg::ST_IDLE;
        end
      end
      zoh_pkg::ST_READ: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_empty_nxt = empty_r;
          out_word_nxt  = empty_r ? '0 : ram_rdata;
          if (!empty_r) begin
            rp_nxt = (rp_r == PTR_LAST) ? '0 : rp_r + 1'b1;
          end
          state_nxt = zoh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = zoh_pkg::ST_IDLE;
      end
    endcase
  end

  // The ring is written only while a push is being expanded, and never past three copies.
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == zoh_pkg::ST_PUSH) && (copies_r != zoh_pkg::MAX_COPIES))
    else $error("ring write outside push expansion or beyond three copies");

  // The frame count never runs past the frame length.
  assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= FRAME_LEN)
    else $error("frame count exceeds frame length");

  // An accepted pull always moves to the read state in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_req_type == zoh_pkg::REQ_PULL)) |=> (state_r == zoh_pkg::ST_READ))
    else $error("pull item not followed by ring read");

  // An empty result carries a zero word.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> (out_word_r == '0))
    else $error("empty result with nonzero word");

endmodule

[bench/tb_top.sv]
// Self-checking bench for the zero-order hold upsampler and its ring FIFO.
module tb_top;

  localparam int RING_DEPTH  = 16384;
  localparam int FRAME_WORDS = 800;
  localparam int SETTLE_CYCLES = 12;

  typedef struct packed {
    logic [zoh_pkg::SAMPLE_W-1:0] word;
    logic                         empty;
  } pull_result_t;

  // Tracks the upsampler and ring state and holds the pull results still to come.
  class zoh_ring_checker;
    logic [zoh_pkg::SAMPLE_W-1:0] ring [RING_DEPTH];
    int unsigned                  head = 0;
    int unsigned                  tail = 0;
    logic [zoh_pkg::PHASE_W-1:0]  phase_acc = '0;
    logic [zoh_pkg::IDX_W-1:0]    src_idx = '0;
    logic [zoh_pkg::IDX_W-1:0]    frame_cnt = '0;
    logic                         rate = zoh_pkg::RATE_HIGH;
    int unsigned                  fail_count = 0;
    pull_result_t                 pending_pulls [$];

    function void accept_request(logic req, logic [zoh_pkg::SAMPLE_W-1:0] word, logic first);
      logic [zoh_pkg::PHASE_W-1:0] inc;
      logic [zoh_pkg::COPY_W:0]    copies;
      pull_result_t                res;
      if (req == zoh_pkg::REQ_PUSH) begin
        inc = (rate == zoh_pkg::RATE_HIGH) ? zoh_pkg::PHASE_W'(zoh_pkg::INC_HIGH) :
                                             zoh_pkg::PHASE_W'(zoh_pkg::INC_LOW);
        if (first) begin
          phase_acc = '0;
          src_idx   = '0;
          frame_cnt = '0;
        end
        // Once the frame is full, pushes are ignored until the next frame starts.
        if (frame_cnt >= FRAME_WORDS) return;
        copies = '0;
        while (copies < zoh_pkg::MAX_COPIES && frame_cnt < FRAME_WORDS &&
               phase_acc[zoh_pkg::PHASE_W-1:zoh_pkg::FRAC_W] == src_idx) begin
          ring[head] = word;
          head = (head + 1) % RING_DEPTH;
          phase_acc = phase_acc + inc;
          frame_cnt = frame_cnt + 1'b1;
          copies = copies + 1'b1;
        end
        src_idx = src_idx + 1'b1;
      end else begin
        if (head == tail) begin
          res.word  = '0;
          res.empty = 1'b1;
        end else begin
          res.word  = ring[tail];
          res.empty = 1'b0;
          tail = (tail + 1) % RING_DEPTH;
        end
        pending_pulls.push_back(res);
      end
    endfunction

    function void check_pull_result(logic [zoh_pkg::SAMPLE_W-1:0] word, logic empty);
      pull_result_t exp_res;
      if (pending_pulls.size() == 0) begin
        $error("out_word: result with no pull pending, actual %h", word);
        fail_count++;
        return;
      end
      exp_res = pending_pulls.pop_front();
      if (word !== exp_res.word) begin
        $error("out_word: expected %h, actual %h", exp_res.word, word);
        fail_count++;
      end
      if (empty !== exp_res.empty) begin
        $error("ring_empty: expected %b, actual %b", exp_res.empty, empty);
        fail_count++;
      end
    endfunction

    function int unsigned pending();
      return pending_pulls.size();
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         in_req_type = zoh_pkg::REQ_PUSH;
  logic [zoh_pkg::SAMPLE_W-1:0] in_sample_word = '0;
  logic                         in_first_of_frame = 1'b0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [zoh_pkg::SAMPLE_W-1:0] out_word;
  logic                         out_ring_empty;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic                         cfg_rate_select = zoh_pkg::RATE_HIGH;

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;

  zoh_ring_checker sb = new;

  zoh_upsampler_ring_fifo_core #(
    .RING_DEPTH (RING_DEPTH),
    .FRAME_WORDS(FRAME_WORDS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_sample_word   (in_sample_word),
    .in_first_of_frame(in_first_of_frame),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_word         (out_word),
    .out_ring_empty   (out_ring_empty),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_rate_select  (cfg_rate_select)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Values read here are those before the edge, so each handshake is seen exactly once.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.accept_request(in_req_type, in_sample_word, in_first_of_frame);
      if (out_valid && out_ready)
        sb.check_pull_result(out_word, out_ring_empty);
    end
  end

  task automatic send_request(logic req, logic [zoh_pkg::SAMPLE_W-1:0] word, logic first);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_req_type       <= req;
    in_sample_word    <= word;
    in_first_of_frame <= first;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_rate(logic rate);
    cfg_valid       <= 1'b1;
    cfg_rate_select <= rate;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.rate = rate;
  endtask

  // A push gives no result, so settle keeps idling after the last pull result to cover any copies still being written.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_frames(int unsigned n_items);
    int unsigned done;
    int unsigned seg_len;
    int unsigned pull_pct;
    done = 0;
    // The first push carries on the frame in progress, so the new rate applies mid-frame.
    send_request(zoh_pkg::REQ_PUSH, $urandom(), 1'b0);
    done++;
    while (done < n_items) begin
      seg_len = ($urandom_range(0, 9) == 0) ? 500 : $urandom_range(5, 60);
      case ($urandom_range(0, 2))
        0:       pull_pct = 20;
        1:       pull_pct = 45;
        default: pull_pct = 80;
      endcase
      send_request(zoh_pkg::REQ_PUSH, $urandom(), ($urandom_range(0, 9) != 0));
      done++;
      if (seg_len > n_items - done)
        seg_len = n_items - done;
      repeat (seg_len) begin
        if ($urandom_range(0, 99) < pull_pct)
          send_request(zoh_pkg::REQ_PULL, $urandom(), 1'($urandom_range(0, 1)));
        else
          send_request(zoh_pkg::REQ_PUSH, $urandom(), ($urandom_range(0, 49) == 0));
        done++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 38;
    recv_idle = 59;
    write_rate(zoh_pkg::RATE_LOW);
    send_request(zoh_pkg::REQ_PULL, 32'h0000_0000, 1'b0);
    send_request(zoh_pkg::REQ_PUSH, 32'h0000_0000, 1'b1);
    send_request(zoh_pkg::REQ_PUSH, 32'hFFFF_FFFF, 1'b0);
    send_request(zoh_pkg::REQ_PUSH, 32'h1234_5678, 1'b0);
    repeat (4) send_request(zoh_pkg::REQ_PULL, 32'hFFFF_FFFF, 1'b1);
    send_request(zoh_pkg::REQ_PUSH, 32'hA5A5_A5A5, 1'b1);
    send_request(zoh_pkg::REQ_PUSH, 32'h5A5A_5A5A, 1'b0);
    repeat (6) send_request(zoh_pkg::REQ_PULL, 32'h0000_0000, 1'b0);
    send_request(zoh_pkg::REQ_PUSH, 32'hDEAD_BEEF, 1'b0);
    send_request(zoh_pkg::REQ_PUSH, 32'h8000_0001, 1'b0);
    settle();

    write_rate(zoh_pkg::RATE_HIGH);
    run_frames(470);
    settle();

    send_idle = 59;
    recv_idle = 38;
    write_rate(zoh_pkg::RATE_LOW);
    run_frames(470);
    settle();

    send_idle = 0;
    recv_idle = 0;
    write_rate(zoh_pkg::RATE_HIGH);
    run_frames(470);
    settle();

    if (sb.fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
design/zoh_pkg.sv
design/zoh_ram.sv
design/zoh_upsampler_ring_fifo_core.sv
bench/tb_top.sv
